>>> sv/tcgr_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_pkg
// Shared types and constants of the text console glyph renderer.
// ----------------------------------------------------------------------------
package tcgr_pkg;

    localparam logic [1:0] FUNC_PRINT = 2'd0;
    localparam logic [1:0] FUNC_LOAD  = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    localparam logic [7:0] CHAR_NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_CR      = 8'd13;

    localparam logic [1:0] CFG_SCREEN_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_SCREEN_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_PITCH    = 2'd2;

    localparam int CFG_W    = 13;
    localparam int CURSOR_W = 12;

    localparam logic [2:0] MAX_SCALE = 3'd4;

    typedef enum logic [1:0] {
        CMD_DRAW,
        CMD_LOAD,
        CMD_CLEAR
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t               op;
        logic [7:0]            char_code;
        logic [31:0]           bg;
        logic [31:0]           fg;
        logic [2:0]            scale;
        logic [3:0]            glyph_row;
        logic [7:0]            row_bits;
        logic [CURSOR_W-1:0]   cursor_x;
        logic [CURSOR_W-1:0]   cursor_y;
        logic [6:0]            scroll;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

endpackage
`default_nettype wire

>>> sv/tcgr_cmd_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_cmd_if
// Command channel: print, glyph row load and clear items.
// ----------------------------------------------------------------------------
interface tcgr_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [7:0]  char_code;
    logic [31:0] background_color;
    logic [31:0] foreground_color;
    logic [2:0]  scale;
    logic [3:0]  glyph_row;
    logic [7:0]  row_bits;

    modport source (
        output valid, func, char_code, background_color, foreground_color,
               scale, glyph_row, row_bits,
        input  ready
    );
    modport sink (
        input  valid, func, char_code, background_color, foreground_color,
               scale, glyph_row, row_bits,
        output ready
    );
endinterface
`default_nettype wire

>>> sv/tcgr_run_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_run_if
// Result channel: scanline runs and clear fills.
// ----------------------------------------------------------------------------
interface tcgr_run_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [23:0] pixel_index;
    logic [31:0] run_mask;
    logic [5:0]  run_length;
    logic [31:0] fg_out;
    logic [31:0] bg_out;
    logic [6:0]  scroll_rows;
    logic        last;

    modport source (
        output valid, kind, pixel_index, run_mask, run_length, fg_out, bg_out,
               scroll_rows, last,
        input  ready
    );
    modport sink (
        input  valid, kind, pixel_index, run_mask, run_length, fg_out, bg_out,
               scroll_rows, last,
        output ready
    );
endinterface
`default_nettype wire

>>> sv/tcgr_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module tcgr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule
`default_nettype wire

>>> sv/tcgr_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_queue
// Short command queue between the front end and the render back end.
// ----------------------------------------------------------------------------
module tcgr_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire tcgr_pkg::cmd_t    push_data,
    input  wire logic              pop,
    output tcgr_pkg::cmd_t         head,
    output tcgr_pkg::q_stat_t      stat
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    tcgr_pkg::cmd_t mem [DEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign stat.full  = (count_reg == CW'(DEPTH));
    assign stat.empty = (count_reg == '0);
    assign head       = mem[rd_ptr_reg];

    assign do_push = push && !stat.full;
    assign do_pop  = pop && !stat.empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule
`default_nettype wire

>>> sv/tcgr_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_front
// Command front end: cursor tracking, wrap and scroll decisions, and
// classification of commands into queue entries.
// ----------------------------------------------------------------------------
module tcgr_front #(
    parameter int GLYPH_ROWS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    tcgr_cmd_if.sink                            cmd,
    input  wire logic [tcgr_pkg::CFG_W-1:0]     screen_width,
    input  wire logic [tcgr_pkg::CFG_W-1:0]     screen_height,
    input  wire tcgr_pkg::q_stat_t              q_stat,
    output logic                                push,
    output tcgr_pkg::cmd_t                      entry
);

    localparam int CW = tcgr_pkg::CURSOR_W;

    function automatic logic [CW-1:0] sat_add(input logic [CW-1:0] a,
                                              input logic [6:0]    b);
        logic [CW:0] s;
        begin
            s = {1'b0, a} + (CW + 1)'(b);
            sat_add = s[CW] ? {CW{1'b1}} : s[CW-1:0];
        end
    endfunction

    logic [CW-1:0] cx_reg, cx_next;
    logic [CW-1:0] cy_reg, cy_next;
    logic          accept;
    logic [2:0]    scale_c;
    logic [6:0]    h;
    logic [5:0]    w;
    logic          wrap, scroll;
    logic [CW-1:0] cx1, cy1, cy2;

    assign cmd.ready = !q_stat.full;
    assign accept    = cmd.valid && cmd.ready;

    always_comb
    begin
        if (cmd.scale == 3'd0)
        begin
            scale_c = 3'd1;
        end
        else if (cmd.scale > tcgr_pkg::MAX_SCALE)
        begin
            scale_c = tcgr_pkg::MAX_SCALE;
        end
        else
        begin
            scale_c = cmd.scale;
        end
        h = {scale_c, 4'b0000};
        w = {scale_c, 3'b000};

        wrap   = ({1'b0, cx_reg} + 13'(w)) > screen_width;
        cx1    = wrap ? '0 : cx_reg;
        cy1    = wrap ? sat_add(cy_reg, h) : cy_reg;
        scroll = ({1'b0, cy1} + 13'(h)) > screen_height;
        if (!scroll)
        begin
            cy2 = cy1;
        end
        else if (cy1 >= CW'(h))
        begin
            cy2 = cy1 - CW'(h);
        end
        else
        begin
            cy2 = '0;
        end

        entry.op        = tcgr_pkg::CMD_DRAW;
        entry.char_code = cmd.char_code;
        entry.bg        = cmd.background_color;
        entry.fg        = cmd.foreground_color;
        entry.scale     = scale_c;
        entry.glyph_row = cmd.glyph_row;
        entry.row_bits  = cmd.row_bits;
        entry.cursor_x  = cx1;
        entry.cursor_y  = cy2;
        entry.scroll    = scroll ? h : 7'd0;

        push    = 1'b0;
        cx_next = cx_reg;
        cy_next = cy_reg;

        if (accept)
        begin
            case (cmd.func)
                tcgr_pkg::FUNC_PRINT:
                begin
                    if (cmd.char_code == tcgr_pkg::CHAR_NEWLINE)
                    begin
                        cy_next = sat_add(cy_reg, h);
                    end
                    else if (cmd.char_code == tcgr_pkg::CHAR_CR)
                    begin
                        cx_next = '0;
                    end
                    else
                    begin
                        push    = 1'b1;
                        cx_next = sat_add(cx1, 7'(w));
                        cy_next = cy2;
                    end
                end
                tcgr_pkg::FUNC_LOAD:
                begin
                    entry.op = tcgr_pkg::CMD_LOAD;
                    push     = (32'(cmd.glyph_row) < GLYPH_ROWS);
                end
                tcgr_pkg::FUNC_CLEAR:
                begin
                    entry.op = tcgr_pkg::CMD_CLEAR;
                    push     = 1'b1;
                    cx_next  = '0;
                    cy_next  = '0;
                end
                default:
                begin
                    push = 1'b0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
        end
        else
        begin
            cx_reg <= cx_next;
            cy_reg <= cy_next;
        end
    end

endmodule
`default_nettype wire

>>> sv/tcgr_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tcgr_back
// Render back end: font store, row sequencer, read stage and output register.
// ----------------------------------------------------------------------------
module tcgr_back #(
    parameter int GLYPH_ROWS = 16
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [tcgr_pkg::CFG_W-1:0]     line_pitch,
    input  wire tcgr_pkg::cmd_t                 head,
    input  wire tcgr_pkg::q_stat_t              q_stat,
    output logic                                pop,
    tcgr_run_if.source                          run
);

    localparam int FONT_DEPTH = 256 * GLYPH_ROWS;
    localparam int AW         = $clog2(FONT_DEPTH);

    typedef enum logic {
        ST_IDLE,
        ST_DRAW
    } state_t;

    function automatic logic [31:0] expand(input logic [7:0] row,
                                           input logic [2:0] scale);
        logic [31:0] m;
        begin
            m = '0;
            case (scale)
                3'd1:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        m[31 - i] = row[7 - i];
                    end
                end
                3'd2:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        for (int k = 0; k < 2; k++)
                        begin
                            m[31 - 2 * i - k] = row[7 - i];
                        end
                    end
                end
                3'd3:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        for (int k = 0; k < 3; k++)
                        begin
                            m[31 - 3 * i - k] = row[7 - i];
                        end
                    end
                end
                default:
                begin
                    for (int i = 0; i < 8; i++)
                    begin
                        for (int k = 0; k < 4; k++)
                        begin
                            m[31 - 4 * i - k] = row[7 - i];
                        end
                    end
                end
            endcase
            expand = m;
        end
    endfunction

    state_t      state_reg, state_next;
    logic [AW-1:0] addr_reg, addr_next;
    logic [1:0]  rep_reg, rep_next;
    logic [6:0]  rows_left_reg, rows_left_next;
    logic [2:0]  scale_reg, scale_next;
    logic [31:0] fg_reg, fg_next;
    logic [31:0] bg_reg, bg_next;
    logic [6:0]  scroll_reg, scroll_next;
    logic [23:0] pix_reg, pix_next;

    logic        p_valid_reg, p_valid_next;
    logic        p_kind_reg, p_kind_next;
    logic [23:0] p_pix_reg, p_pix_next;
    logic [5:0]  p_len_reg, p_len_next;
    logic [31:0] p_fg_reg, p_fg_next;
    logic [31:0] p_bg_reg, p_bg_next;
    logic [2:0]  p_scale_reg, p_scale_next;
    logic [6:0]  p_scroll_reg, p_scroll_next;
    logic        p_last_reg, p_last_next;

    logic        out_valid_reg, out_valid_next;
    logic        out_kind_reg, out_kind_next;
    logic [23:0] out_pix_reg, out_pix_next;
    logic [31:0] out_mask_reg, out_mask_next;
    logic [5:0]  out_len_reg, out_len_next;
    logic [31:0] out_fg_reg, out_fg_next;
    logic [31:0] out_bg_reg, out_bg_next;
    logic [6:0]  out_scroll_reg, out_scroll_next;
    logic        out_last_reg, out_last_next;

    logic          en;
    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [7:0]    ram_rdata;
    logic [24:0]   prod;

    assign en  = !out_valid_reg || run.ready;
    assign pop = en && (state_reg == ST_IDLE) && !q_stat.empty;

    assign ram_we    = pop && (head.op == tcgr_pkg::CMD_LOAD);
    assign ram_waddr = AW'(32'(head.char_code) * GLYPH_ROWS + 32'(head.glyph_row));
    assign prod      = 25'(head.cursor_y) * 25'(line_pitch);

    tcgr_ram #(
        .WIDTH (8),
        .DEPTH (FONT_DEPTH)
    ) u_font (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (head.row_bits),
        .re    (en),
        .raddr (addr_reg),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next     = state_reg;
        addr_next      = addr_reg;
        rep_next       = rep_reg;
        rows_left_next = rows_left_reg;
        scale_next     = scale_reg;
        fg_next        = fg_reg;
        bg_next        = bg_reg;
        scroll_next    = scroll_reg;
        pix_next       = pix_reg;

        p_valid_next  = p_valid_reg;
        p_kind_next   = p_kind_reg;
        p_pix_next    = p_pix_reg;
        p_len_next    = p_len_reg;
        p_fg_next     = p_fg_reg;
        p_bg_next     = p_bg_reg;
        p_scale_next  = p_scale_reg;
        p_scroll_next = p_scroll_reg;
        p_last_next   = p_last_reg;

        out_valid_next  = out_valid_reg;
        out_kind_next   = out_kind_reg;
        out_pix_next    = out_pix_reg;
        out_mask_next   = out_mask_reg;
        out_len_next    = out_len_reg;
        out_fg_next     = out_fg_reg;
        out_bg_next     = out_bg_reg;
        out_scroll_next = out_scroll_reg;
        out_last_next   = out_last_reg;

        if (en)
        begin
            out_valid_next  = p_valid_reg;
            out_kind_next   = p_kind_reg;
            out_pix_next    = p_pix_reg;
            out_mask_next   = p_kind_reg ? 32'd0 : expand(ram_rdata, p_scale_reg);
            out_len_next    = p_len_reg;
            out_fg_next     = p_fg_reg;
            out_bg_next     = p_bg_reg;
            out_scroll_next = p_scroll_reg;
            out_last_next   = p_last_reg;

            p_valid_next = 1'b0;

            case (state_reg)
                ST_IDLE:
                begin
                    if (!q_stat.empty)
                    begin
                        case (head.op)
                            tcgr_pkg::CMD_CLEAR:
                            begin
                                p_valid_next  = 1'b1;
                                p_kind_next   = 1'b1;
                                p_pix_next    = '0;
                                p_len_next    = '0;
                                p_fg_next     = '0;
                                p_bg_next     = head.bg;
                                p_scale_next  = 3'd1;
                                p_scroll_next = '0;
                                p_last_next   = 1'b1;
                            end
                            tcgr_pkg::CMD_DRAW:
                            begin
                                state_next     = ST_DRAW;
                                addr_next      = AW'(32'(head.char_code) * GLYPH_ROWS);
                                rep_next       = '0;
                                rows_left_next = {head.scale, 4'b0000};
                                scale_next     = head.scale;
                                fg_next        = head.fg;
                                bg_next        = head.bg;
                                scroll_next    = head.scroll;
                                pix_next       = prod[23:0] + 24'(head.cursor_x);
                            end
                            default:
                            begin
                                p_valid_next = 1'b0;
                            end
                        endcase
                    end
                end
                ST_DRAW:
                begin
                    p_valid_next  = 1'b1;
                    p_kind_next   = 1'b0;
                    p_pix_next    = pix_reg;
                    p_len_next    = {scale_reg, 3'b000};
                    p_fg_next     = fg_reg;
                    p_bg_next     = bg_reg;
                    p_scale_next  = scale_reg;
                    p_scroll_next = scroll_reg;
                    p_last_next   = (rows_left_reg == 7'd1);

                    pix_next       = pix_reg + 24'(line_pitch);
                    scroll_next    = '0;
                    rows_left_next = rows_left_reg - 7'd1;
                    if (rows_left_reg == 7'd1)
                    begin
                        state_next = ST_IDLE;
                    end
                    if ((3'(rep_reg) + 3'd1) == scale_reg)
                    begin
                        rep_next  = '0;
                        addr_next = (addr_reg == AW'(FONT_DEPTH - 1)) ? '0
                                                                       : addr_reg + 1'b1;
                    end
                    else
                    begin
                        rep_next = rep_reg + 2'd1;
                    end
                end
                default:
                begin
                    state_next = ST_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            addr_reg       <= '0;
            rep_reg        <= '0;
            rows_left_reg  <= '0;
            scale_reg      <= 3'd1;
            fg_reg         <= '0;
            bg_reg         <= '0;
            scroll_reg     <= '0;
            pix_reg        <= '0;
            p_valid_reg    <= 1'b0;
            p_kind_reg     <= 1'b0;
            p_pix_reg      <= '0;
            p_len_reg      <= '0;
            p_fg_reg       <= '0;
            p_bg_reg       <= '0;
            p_scale_reg    <= 3'd1;
            p_scroll_reg   <= '0;
            p_last_reg     <= 1'b0;
            out_valid_reg  <= 1'b0;
            out_kind_reg   <= 1'b0;
            out_pix_reg    <= '0;
            out_mask_reg   <= '0;
            out_len_reg    <= '0;
            out_fg_reg     <= '0;
            out_bg_reg     <= '0;
            out_scroll_reg <= '0;
            out_last_reg   <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            addr_reg       <= addr_next;
            rep_reg        <= rep_next;
            rows_left_reg  <= rows_left_next;
            scale_reg      <= scale_next;
            fg_reg         <= fg_next;
            bg_reg         <= bg_next;
            scroll_reg     <= scroll_next;
            pix_reg        <= pix_next;
            p_valid_reg    <= p_valid_next;
            p_kind_reg     <= p_kind_next;
            p_pix_reg      <= p_pix_next;
            p_len_reg      <= p_len_next;
            p_fg_reg       <= p_fg_next;
            p_bg_reg       <= p_bg_next;
            p_scale_reg    <= p_scale_next;
            p_scroll_reg   <= p_scroll_next;
            p_last_reg     <= p_last_next;
            out_valid_reg  <= out_valid_next;
            out_kind_reg   <= out_kind_next;
            out_pix_reg    <= out_pix_next;
            out_mask_reg   <= out_mask_next;
            out_len_reg    <= out_len_next;
            out_fg_reg     <= out_fg_next;
            out_bg_reg     <= out_bg_next;
            out_scroll_reg <= out_scroll_next;
            out_last_reg   <= out_last_next;
        end
    end

    assign run.valid       = out_valid_reg;
    assign run.kind        = out_kind_reg;
    assign run.pixel_index = out_pix_reg;
    assign run.run_mask    = out_mask_reg;
    assign run.run_length  = out_len_reg;
    assign run.fg_out      = out_fg_reg;
    assign run.bg_out      = out_bg_reg;
    assign run.scroll_rows = out_scroll_reg;
    assign run.last        = out_last_reg;

endmodule
`default_nettype wire

>>> sv/text_console_glyph_renderer_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top
// Text console engine: font store, cursor, and scanline run generation.
// ----------------------------------------------------------------------------
// A glyph's first run passes the queue, the row sequencer, the read stage and
// the output register; a clear fill skips the row sequencer; loads and cursor
// moves give nothing. The row sequencer gives one run per cycle unless run.ready
// stalls it. A glyph is 16*scale runs, after a setup step (address multiply).
// Reset: cursor at 0,0, screen 640x480 with pitch 640, queue and pipeline
// empty; font contents are undefined until loaded.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top #(
    parameter int GLYPH_ROWS  = 16,
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    tcgr_cmd_if.sink                         cmd,
    tcgr_run_if.source                       run,
    input  wire logic                        cfg_we,
    input  wire logic [1:0]                  cfg_index,
    input  wire logic [tcgr_pkg::CFG_W-1:0]  cfg_data
);

    logic [tcgr_pkg::CFG_W-1:0] screen_width_reg;
    logic [tcgr_pkg::CFG_W-1:0] screen_height_reg;
    logic [tcgr_pkg::CFG_W-1:0] line_pitch_reg;

    tcgr_pkg::q_stat_t q_stat;
    tcgr_pkg::cmd_t    entry;
    tcgr_pkg::cmd_t    head;
    logic              push;
    logic              pop;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            screen_width_reg  <= 13'd640;
            screen_height_reg <= 13'd480;
            line_pitch_reg    <= 13'd640;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                tcgr_pkg::CFG_SCREEN_WIDTH:  screen_width_reg  <= cfg_data;
                tcgr_pkg::CFG_SCREEN_HEIGHT: screen_height_reg <= cfg_data;
                tcgr_pkg::CFG_LINE_PITCH:    line_pitch_reg    <= cfg_data;
                default:                     line_pitch_reg    <= line_pitch_reg;
            endcase
        end
    end

    tcgr_front #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .screen_width  (screen_width_reg),
        .screen_height (screen_height_reg),
        .q_stat        (q_stat),
        .push          (push),
        .entry         (entry)
    );

    tcgr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .pop       (pop),
        .head      (head),
        .stat      (q_stat)
    );

    tcgr_back #(
        .GLYPH_ROWS (GLYPH_ROWS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .line_pitch (line_pitch_reg),
        .head       (head),
        .q_stat     (q_stat),
        .pop        (pop),
        .run        (run)
    );

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        q_stat.full |-> !cmd.ready)
        else $error("command accepted while queue full");

    a_clear_last: assert property (@(posedge clk) disable iff (!rst_n)
        run.valid && run.kind |-> run.last && run.run_length == 6'd0)
        else $error("clear fill not a single final result");

    a_run_len: assert property (@(posedge clk) disable iff (!rst_n)
        run.valid && !run.kind |-> (run.run_length == 6'd8 || run.run_length == 6'd16
                                 || run.run_length == 6'd24 || run.run_length == 6'd32))
        else $error("bad run length");

    a_scroll_h: assert property (@(posedge clk) disable iff (!rst_n)
        run.valid && run.scroll_rows != 7'd0 |-> run.scroll_rows == {run.run_length, 1'b0})
        else $error("scroll amount does not match glyph height");

endmodule
`default_nettype wire

>>> dv/text_console_glyph_renderer_top_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_glyph_renderer_top_test
// Self-checking testbench of the text console glyph renderer. A directed
// table (glyph loads, clears, prints at every scale class, cursor moves)
// runs first. Random traffic follows over several screen settings,
// including the extremes. An internal font and cursor model predicts every
// scanline run and fill, and each transfer on the run channel is compared
// against it.
// ----------------------------------------------------------------------------
module text_console_glyph_renderer_top_test;

    localparam logic [1:0] FUNC_RESERVED = 2'd3;
    localparam logic       KIND_RUN      = 1'b0;
    localparam logic       KIND_FILL     = 1'b1;
    localparam int CURSOR_MAX     = (1 << tcgr_pkg::CURSOR_W) - 1;
    localparam int NUM_PHASES     = 6;
    localparam int PHASE_ITEMS    = 40;
    localparam int HOLD_CYCLES    = 400;
    localparam int SETTLE_CYCLES  = 16;
    localparam int WATCHDOG_LIMIT = 2000;

    typedef struct packed {
        logic [1:0]  func;
        logic [7:0]  code;
        logic [31:0] bg;
        logic [31:0] fg;
        logic [2:0]  scale;
        logic [3:0]  grow;
        logic [7:0]  bits;
    } cmd_item_t;

    typedef struct packed {
        logic        kind;
        logic [23:0] pix;
        logic [31:0] mask;
        logic [5:0]  len;
        logic [31:0] fg;
        logic [31:0] bg;
        logic [6:0]  scroll;
        logic        last;
    } run_t;

    typedef struct packed {
        cmd_item_t item;
        logic [4:0] reps;
        logic       typed;
        run_t       first;
    } dir_row_t;

    localparam run_t RUN_NONE = '0;

    // Glyph 0xFF: rows 0..13 walk a single bit (inverted from row 8), row 14
    // all clear, row 15 all set.
    dir_row_t dir_tab [12] = '{
        '{'{FUNC_RESERVED, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 3'd7, 4'hF, 8'hFF},
          5'd1, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_CLEAR, 8'h00, 32'hFFFF_FFFF, 32'h0, 3'd1, 4'h0, 8'h00},
          5'd1, 1'b1, '{KIND_FILL, 24'd0, 32'd0, 6'd0, 32'd0, 32'hFFFF_FFFF, 7'd0, 1'b1}},
        '{'{tcgr_pkg::FUNC_LOAD, 8'hFF, 32'h0, 32'h0, 3'd0, 4'd0, 8'h80},
          5'd14, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_LOAD, 8'hFF, 32'h0, 32'h0, 3'd0, 4'd14, 8'h00},
          5'd1, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_LOAD, 8'hFF, 32'h0, 32'h0, 3'd0, 4'd15, 8'hFF},
          5'd1, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_PRINT, 8'hFF, 32'hFFFF_FFFF, 32'h0, 3'd1, 4'h0, 8'h00},
          5'd1, 1'b1, '{KIND_RUN, 24'd0, 32'h8000_0000, 6'd8, 32'h0, 32'hFFFF_FFFF,
                        7'd0, 1'b0}},
        '{'{tcgr_pkg::FUNC_PRINT, 8'hFF, 32'h0, 32'hFFFF_FFFF, 3'd4, 4'h0, 8'h00},
          5'd1, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_PRINT, 8'hFF, 32'h1234_5678, 32'h8765_4321, 3'd0, 4'h0, 8'h00},
          5'd1, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_PRINT, 8'hFF, 32'hA5A5_A5A5, 32'h5A5A_5A5A, 3'd7, 4'h0, 8'h00},
          5'd1, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_PRINT, tcgr_pkg::CHAR_NEWLINE, 32'h0, 32'h0, 3'd2, 4'h0, 8'h00},
          5'd1, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_PRINT, tcgr_pkg::CHAR_CR, 32'h0, 32'h0, 3'd1, 4'h0, 8'h00},
          5'd1, 1'b0, RUN_NONE},
        '{'{tcgr_pkg::FUNC_CLEAR, 8'h00, 32'h0, 32'hFFFF_FFFF, 3'd3, 4'h0, 8'h00},
          5'd1, 1'b1, '{KIND_FILL, 24'd0, 32'd0, 6'd0, 32'd0, 32'h0, 7'd0, 1'b1}}
    };

    logic clk = 1'b0;
    logic rst_n;
    logic cfg_we;
    logic [1:0] cfg_index;
    logic [tcgr_pkg::CFG_W-1:0] cfg_data;

    tcgr_cmd_if cmd_ch ();
    tcgr_run_if run_ch ();

    text_console_glyph_renderer_top u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd_ch),
        .run       (run_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    logic [7:0]                   glyph_font [0:4095];
    logic [15:0]                  font_rows [0:255];
    bit                           glyph_ready [0:255];
    logic [7:0]                   ready_codes [$];
    logic [tcgr_pkg::CURSOR_W-1:0] cur_x = '0;
    logic [tcgr_pkg::CURSOR_W-1:0] cur_y = '0;
    logic [tcgr_pkg::CFG_W-1:0]   scr_w = 13'd640;
    logic [tcgr_pkg::CFG_W-1:0]   scr_h = 13'd480;
    logic [tcgr_pkg::CFG_W-1:0]   pitch = 13'd640;
    run_t                         pending_runs [$];
    int                           err_count = 0;
    int                           cmds_sent = 0;
    int                           idle_cycles = 0;
    bit                           idle_en = 1'b1;
    bit                           hold_req = 1'b0;

    function automatic logic [tcgr_pkg::CURSOR_W-1:0] sat_cursor(input int v);
        return (v > CURSOR_MAX) ? CURSOR_MAX[tcgr_pkg::CURSOR_W-1:0]
                                : v[tcgr_pkg::CURSOR_W-1:0];
    endfunction

    task automatic render_cmd(input cmd_item_t it, input bit typed, input run_t first);
        int sc;
        int h;
        int w;
        int scroll;
        logic [3:0] grow_idx;
        logic [7:0] bits;
        logic [31:0] mask;
        longint pix;
        run_t r;
        case (it.func)
            tcgr_pkg::FUNC_LOAD:
            begin
                glyph_font[{it.code, it.grow}] = it.bits;
                font_rows[it.code][it.grow] = 1'b1;
                if (&font_rows[it.code] && !glyph_ready[it.code])
                begin
                    glyph_ready[it.code] = 1'b1;
                    ready_codes.push_back(it.code);
                end
            end
            tcgr_pkg::FUNC_CLEAR:
            begin
                cur_x = '0;
                cur_y = '0;
                r = '{KIND_FILL, 24'd0, 32'd0, 6'd0, 32'd0, it.bg, 7'd0, 1'b1};
                pending_runs.push_back(typed ? first : r);
            end
            tcgr_pkg::FUNC_PRINT:
            begin
                sc = int'(it.scale);
                if (sc < 1)
                    sc = 1;
                if (sc > int'(tcgr_pkg::MAX_SCALE))
                    sc = int'(tcgr_pkg::MAX_SCALE);
                h = 16 * sc;
                w = 8 * sc;
                if (it.code == tcgr_pkg::CHAR_NEWLINE)
                    cur_y = sat_cursor(int'(cur_y) + h);
                else if (it.code == tcgr_pkg::CHAR_CR)
                    cur_x = '0;
                else
                begin
                    if (int'(cur_x) + w > int'(scr_w))
                    begin
                        cur_x = '0;
                        cur_y = sat_cursor(int'(cur_y) + h);
                    end
                    scroll = 0;
                    if (int'(cur_y) + h > int'(scr_h))
                    begin
                        scroll = h;
                        cur_y = (int'(cur_y) >= h) ? cur_y - h[tcgr_pkg::CURSOR_W-1:0] : '0;
                    end
                    for (int y = 0; y < h; y++)
                    begin
                        grow_idx = 4'(y / sc);
                        bits = glyph_font[{it.code, grow_idx}];
                        mask = '0;
                        for (int x = 0; x < w; x++)
                            if (bits[7 - x / sc])
                                mask[31 - x] = 1'b1;
                        pix = longint'(cur_x) + longint'(int'(cur_y) + y) * longint'(pitch);
                        r.kind   = KIND_RUN;
                        r.pix    = pix[23:0];
                        r.mask   = mask;
                        r.len    = 6'(w);
                        r.fg     = it.fg;
                        r.bg     = it.bg;
                        r.scroll = (y == 0) ? 7'(scroll) : 7'd0;
                        r.last   = (y == h - 1);
                        pending_runs.push_back((typed && y == 0) ? first : r);
                    end
                    cur_x = sat_cursor(int'(cur_x) + w);
                end
            end
            default: ;
        endcase
    endtask

    task automatic send_cmd(input cmd_item_t it, input bit typed = 1'b0,
                            input run_t first = '0);
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            cmd_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        cmd_ch.valid            <= 1'b1;
        cmd_ch.func             <= it.func;
        cmd_ch.char_code        <= it.code;
        cmd_ch.background_color <= it.bg;
        cmd_ch.foreground_color <= it.fg;
        cmd_ch.scale            <= it.scale;
        cmd_ch.glyph_row        <= it.grow;
        cmd_ch.row_bits         <= it.bits;
        @(posedge clk);
        while (!cmd_ch.ready)
            @(posedge clk);
        render_cmd(it, typed, first);
        cmds_sent++;
    endtask

    task automatic apply_screen(input int w, input int h, input int p);
        cfg_we    <= 1'b1;
        cfg_index <= tcgr_pkg::CFG_SCREEN_WIDTH;
        cfg_data  <= tcgr_pkg::CFG_W'(w);
        @(posedge clk);
        scr_w = tcgr_pkg::CFG_W'(w);
        cfg_index <= tcgr_pkg::CFG_SCREEN_HEIGHT;
        cfg_data  <= tcgr_pkg::CFG_W'(h);
        @(posedge clk);
        scr_h = tcgr_pkg::CFG_W'(h);
        cfg_index <= tcgr_pkg::CFG_LINE_PITCH;
        cfg_data  <= tcgr_pkg::CFG_W'(p);
        @(posedge clk);
        pitch = tcgr_pkg::CFG_W'(p);
        cfg_we <= 1'b0;
    endtask

    task automatic drain_runs();
        cmd_ch.valid <= 1'b0;
        while (pending_runs.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic cmd_item_t rand_item(input logic [1:0] func);
        cmd_item_t it;
        it.func  = func;
        it.code  = 8'($urandom);
        it.bg    = $urandom;
        it.fg    = $urandom;
        it.scale = 3'($urandom);
        it.grow  = 4'($urandom);
        it.bits  = 8'($urandom);
        return it;
    endfunction

    function automatic cmd_item_t make_print(input logic [7:0] code, input logic [2:0] scale);
        cmd_item_t it;
        it = rand_item(tcgr_pkg::FUNC_PRINT);
        it.code  = code;
        it.scale = scale;
        return it;
    endfunction

    function automatic logic [7:0] pick_code();
        return ready_codes[$urandom_range(0, ready_codes.size() - 1)];
    endfunction

    task automatic load_glyph(input logic [7:0] code);
        int order [$];
        cmd_item_t it;
        for (int i = 0; i < 16; i++)
            order.push_back(i);
        order.shuffle();
        foreach (order[i])
        begin
            it = rand_item(tcgr_pkg::FUNC_LOAD);
            it.code = code;
            it.grow = 4'(order[i]);
            send_cmd(it);
        end
    endtask

    task automatic random_step();
        int pick;
        int n;
        logic [2:0] sc;
        pick = $urandom_range(0, 99);
        sc = 3'($urandom_range(0, 7));
        if (ready_codes.size() == 0 || pick < 10)
            load_glyph(8'($urandom));
        else if (pick < 18)
            send_cmd(rand_item(tcgr_pkg::FUNC_LOAD));
        else if (pick < 26)
        begin
            n = $urandom_range(1, 4);
            repeat (n) send_cmd(make_print(tcgr_pkg::CHAR_NEWLINE, sc));
        end
        else if (pick < 31)
            send_cmd(make_print(tcgr_pkg::CHAR_CR, sc));
        else if (pick < 34)
            send_cmd(rand_item(tcgr_pkg::FUNC_CLEAR));
        else if (pick < 36)
            send_cmd(rand_item(FUNC_RESERVED));
        else if (pick < 42)
        begin
            n = $urandom_range(4, 24);
            repeat (n) send_cmd(make_print(pick_code(), sc));
        end
        else
            send_cmd(make_print(pick_code(), sc));
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", name, want, got);
            err_count++;
        end
    endtask

    always @(posedge clk)
    begin : run_check
        run_t want;
        if (rst_n && run_ch.valid && run_ch.ready)
        begin
            if (pending_runs.size() == 0)
            begin
                $error("run transfer with no expected result");
                err_count++;
            end
            else
            begin
                want = pending_runs.pop_front();
                check_field("kind", 32'(want.kind), 32'(run_ch.kind));
                check_field("pixel_index", 32'(want.pix), 32'(run_ch.pixel_index));
                check_field("run_mask", want.mask, run_ch.run_mask);
                check_field("run_length", 32'(want.len), 32'(run_ch.run_length));
                check_field("fg_out", want.fg, run_ch.fg_out);
                check_field("bg_out", want.bg, run_ch.bg_out);
                check_field("scroll_rows", 32'(want.scroll), 32'(run_ch.scroll_rows));
                check_field("last", 32'(want.last), 32'(run_ch.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (cmd_ch.valid && cmd_ch.ready)
            || (run_ch.valid && run_ch.ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("Verification failed");
                $finish;
            end
        end
    end

    // result sink: short random stalls, plus one long hold-off on request
    initial
    begin : run_sink
        int stall_left;
        stall_left = 0;
        run_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                run_ch.ready <= 1'b0;
            else if (hold_req)
            begin
                hold_req = 1'b0;
                run_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else if (stall_left > 0)
            begin
                stall_left--;
                run_ch.ready <= 1'b0;
            end
            else if (idle_en && $urandom_range(0, 4) == 0)
            begin
                stall_left = $urandom_range(0, 2);
                run_ch.ready <= 1'b0;
            end
            else
                run_ch.ready <= 1'b1;
        end
    end

    initial
    begin : stimulus
        cmd_item_t it;
        int goal;
        rst_n                   <= 1'b0;
        cfg_we                  <= 1'b0;
        cfg_index               <= tcgr_pkg::CFG_SCREEN_WIDTH;
        cfg_data                <= '0;
        cmd_ch.valid            <= 1'b0;
        cmd_ch.func             <= tcgr_pkg::FUNC_PRINT;
        cmd_ch.char_code        <= '0;
        cmd_ch.background_color <= '0;
        cmd_ch.foreground_color <= '0;
        cmd_ch.scale            <= 3'd1;
        cmd_ch.glyph_row        <= '0;
        cmd_ch.row_bits         <= '0;
        foreach (font_rows[i])
            font_rows[i] = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table against the reset screen settings
        foreach (dir_tab[i])
            for (int r = 0; r < int'(dir_tab[i].reps); r++)
            begin
                it = dir_tab[i].item;
                if (dir_tab[i].reps > 1)
                begin
                    it.grow = dir_tab[i].item.grow + 4'(r);
                    it.bits = ((it.bits >> (r % 8)) | (it.bits << (8 - r % 8)))
                              ^ {8{r[3]}};
                end
                send_cmd(it, dir_tab[i].typed, dir_tab[i].first);
            end
        drain_runs();

        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            case (ph)
                0: apply_screen(1, 1, 1);
                1: apply_screen(4096, 4096, 4096);
                3: apply_screen(8, 16, 4096);
                NUM_PHASES - 1: apply_screen(640, 480, 640);
                default: apply_screen($urandom_range(1, 4096), $urandom_range(1, 4096),
                                      $urandom_range(1, 4096));
            endcase
            idle_en = (ph != NUM_PHASES - 1);
            if (ph == 2)
                hold_req = 1'b1;
            if (ph == 1)
            begin
                // full-width line saturates cursor X, then newlines saturate Y
                send_cmd(make_print(tcgr_pkg::CHAR_CR, 3'd4));
                repeat (129) send_cmd(make_print(pick_code(), 3'd4));
                repeat (65) send_cmd(make_print(tcgr_pkg::CHAR_NEWLINE, 3'd4));
                send_cmd(make_print(pick_code(), 3'd4));
            end
            goal = cmds_sent + PHASE_ITEMS;
            while (cmds_sent < goal)
                random_step();
            drain_runs();
        end

        if (err_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

>>> sim.f
sv/tcgr_pkg.sv
sv/tcgr_cmd_if.sv
sv/tcgr_run_if.sv
sv/tcgr_ram.sv
sv/tcgr_queue.sv
sv/tcgr_front.sv
sv/tcgr_back.sv
sv/text_console_glyph_renderer_top.sv
dv/text_console_glyph_renderer_top_test.sv
